FILE: hdl/b2da_pkg.sv
// b2da_pkg: types and constants shared by the binary to decimal ASCII block.
// No dependencies; every other file in hdl/ uses this package.
`default_nettype none

package b2da_pkg;

  localparam int NUM_W      = 32;
  localparam int DIGITS     = 10;
  localparam int DIGIT_W    = 4;
  localparam int TOP_W      = $clog2(DIGITS);
  localparam int CHAR_W     = 6;
  localparam int ITER_W     = $clog2(NUM_W);
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef logic [DIGITS-1:0][DIGIT_W-1:0] b2da_bcd_t;

  // one converted value waiting for emission
  typedef struct packed {
    b2da_bcd_t        bcd;
    logic [TOP_W-1:0] top;  // index of most significant non-zero digit
  } b2da_entry_t;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_SHIFT,
    FRONT_PUSH
  } b2da_front_state_t;

endpackage

`default_nettype wire

FILE: hdl/b2da_ifs.sv
// b2da_ifs: valid/ready channel interfaces for the number input and text output.
// Depends on b2da_pkg for field widths.
`default_nettype none

interface b2da_num_if;
  logic                         valid;
  logic                         ready;
  logic [b2da_pkg::NUM_W-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2da_text_if;
  logic                         valid;
  logic                         ready;
  logic [b2da_pkg::CHAR_W-1:0]  digit_char;
  logic                         last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/binary_to_decimal_ascii_top.sv
// binary_to_decimal_ascii_top: unsigned 32-bit value to decimal ASCII digits.
// Instantiates b2da_front, b2da_queue, b2da_back; uses b2da_pkg, b2da_ifs.
//
//   channel  dir   payload                  per transfer
//   num      sink  value[31:0]              one value to print
//   text     src   digit_char[5:0], last    one digit, last on least significant
//
// The converter works in steps: one to accept, 32 shift-and-add-3 steps
// (one input bit each), one to write the queue. The emitter sends one digit
// per cycle while text.ready is high, 1 to 10 per value, from the queue while
// the next value converts. A stalled output holds the emitter, then the queue,
// then input. Reset clears state machines, pointers, fill and valid flags only.
`default_nettype none

module binary_to_decimal_ascii_top #(
  parameter int QUEUE_DEPTH = b2da_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  b2da_num_if.sink    num,
  b2da_text_if.source text
);

  logic                  fq_valid, fq_ready, qb_valid, qb_ready;
  b2da_pkg::b2da_entry_t fq_data, qb_data;

  b2da_front u_front (
    .clk     (clk),
    .rst     (rst),
    .num     (num),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_data  (fq_data)
  );

  b2da_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  b2da_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .q_data  (qb_data),
    .text    (text)
  );

endmodule

`default_nettype wire

FILE: hdl/b2da_front.sv
// b2da_front: accepts a value and converts it to BCD by shift-and-add-3,
// one bit per cycle, then hands the digits to the queue. Uses b2da_pkg, b2da_ifs.
`default_nettype none

module b2da_front (
  input  wire logic              clk,
  input  wire logic              rst,
  b2da_num_if.sink               num,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output b2da_pkg::b2da_entry_t  q_data
);

  b2da_pkg::b2da_front_state_t      state, state_next;
  logic [b2da_pkg::NUM_W-1:0]       shift;
  b2da_pkg::b2da_bcd_t              bcd;
  logic [b2da_pkg::ITER_W-1:0]      cnt;
  b2da_pkg::b2da_bcd_t              bcd_adj;
  logic [b2da_pkg::DIGITS*b2da_pkg::DIGIT_W-1:0] bcd_flat;
  logic [b2da_pkg::TOP_W-1:0]       top;

  // add 3 to every digit of 5 or more ahead of the shift
  always_comb begin
    for (int k = 0; k < b2da_pkg::DIGITS; k++) begin
      bcd_adj[k] = (bcd[k] >= 4'd5) ? bcd[k] + 4'd3 : bcd[k];
    end
  end

  // digits as one flat vector so the shift moves bits across digit borders
  assign bcd_flat = bcd_adj;

  // highest non-zero digit; zero value gives index 0
  always_comb begin
    top = '0;
    for (int k = 0; k < b2da_pkg::DIGITS; k++) begin
      if (bcd[k] != '0) top = b2da_pkg::TOP_W'(k);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      b2da_pkg::FRONT_IDLE: begin
        if (num.valid) state_next = b2da_pkg::FRONT_SHIFT;
      end
      b2da_pkg::FRONT_SHIFT: begin
        if (cnt == b2da_pkg::ITER_W'(b2da_pkg::NUM_W - 1)) state_next = b2da_pkg::FRONT_PUSH;
      end
      b2da_pkg::FRONT_PUSH: begin
        if (q_ready) state_next = b2da_pkg::FRONT_IDLE;
      end
      default: state_next = b2da_pkg::FRONT_IDLE;
    endcase
  end

  always_comb begin
    num.ready  = (state == b2da_pkg::FRONT_IDLE);
    q_valid    = (state == b2da_pkg::FRONT_PUSH);
    q_data.bcd = bcd;
    q_data.top = top;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= b2da_pkg::FRONT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == b2da_pkg::FRONT_IDLE && num.valid) begin
      shift <= num.value;
      bcd   <= '0;
      cnt   <= '0;
    end else if (state == b2da_pkg::FRONT_SHIFT) begin
      bcd   <= {bcd_flat[b2da_pkg::DIGITS*b2da_pkg::DIGIT_W-2:0], shift[b2da_pkg::NUM_W-1]};
      shift <= {shift[b2da_pkg::NUM_W-2:0], 1'b0};
      cnt   <= cnt + 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/b2da_queue.sv
// b2da_queue: short FIFO of converted values between the converter and emitter.
// Uses b2da_pkg for the entry type.
`default_nettype none

module b2da_queue #(
  parameter int DEPTH = b2da_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push_valid,
  output logic                       push_ready,
  input  wire b2da_pkg::b2da_entry_t push_data,
  output logic                       pop_valid,
  input  wire logic                  pop_ready,
  output b2da_pkg::b2da_entry_t      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b2da_pkg::b2da_entry_t mem [DEPTH];
  logic [PTR_W-1:0]      wr_ptr, rd_ptr;
  logic [CNT_W-1:0]      fill;
  logic                  do_push, do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/b2da_back.sv
// b2da_back: takes converted values from the queue and emits one ASCII digit
// per transfer, most significant first, through an output register.
// Uses b2da_pkg, b2da_ifs.
`default_nettype none

module b2da_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire b2da_pkg::b2da_entry_t q_data,
  b2da_text_if.source                text
);

  logic                          active;
  b2da_pkg::b2da_bcd_t           bcd;
  logic [b2da_pkg::TOP_W-1:0]    idx;
  logic                          out_valid;
  logic [b2da_pkg::CHAR_W-1:0]   out_char;
  logic                          out_last;
  logic                          emit;

  assign q_ready = !active;
  assign emit    = active && (!out_valid || text.ready);

  assign text.valid      = out_valid;
  assign text.digit_char = out_char;
  assign text.last       = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!active && q_valid) begin
        active <= 1'b1;
      end else if (emit && idx == '0) begin
        active <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!active && q_valid) begin
      bcd <= q_data.bcd;
      idx <= q_data.top;
    end else if (emit) begin
      idx <= idx - 1'b1;
    end
    if (emit) begin
      out_char <= b2da_pkg::ASCII_ZERO + {2'b00, bcd[idx]};
      out_last <= (idx == '0);
    end
  end

endmodule

`default_nettype wire
